// File: src/ped_pkg.sv
// Shared constants and types for the pairwise Euclidean distance unit.
package ped_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int IDX_W        = $clog2(MAX_VERTICES);
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
   localparam int COORD_W      = 24;
   localparam int DIFF_W       = COORD_W;
   localparam int SQ_W         = 2 * DIFF_W;
   localparam int RAD_W        = SQ_W + 2;
   localparam int ROOT_W       = RAD_W / 2;
   localparam int REM_W        = ROOT_W + 1;
   localparam int OUT_IDX_W    = 6;
   localparam int DIST_W       = 25;
   localparam int REQ_DATA_W   = 48;
   localparam int RSP_DATA_W   = 40;

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } ped_state_type;

   typedef struct packed {
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] x;
   } ped_point_type;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] earlier_index;
      logic [OUT_IDX_W-1:0] new_index;
      logic                 last;
   } ped_tag_type;

endpackage

// File: src/pairwise_euclidean_distance_unit.sv
// Top level: vertex store, scan sequencer, distance pipeline and result register.
// Throughput: a vertex given index n reads the vertex memory once per earlier vertex after
//   it is accepted, and no new vertex is taken during that scan; results stream one per
//   cycle while rsp_tready does not stall them.
// The 25-stage square root pipeline and the single memory read port set this behaviour.
// Reset (synchronous, active high) clears the vertex count, sequencer and valid bits only.
module pairwise_euclidean_distance_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [ped_pkg::REQ_DATA_W-1:0]   req_tdata,  // coord_x[23:0], coord_y[47:24]
   input  logic                             req_tuser,  // restart
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [ped_pkg::RSP_DATA_W-1:0]   rsp_tdata,  // earlier_index[5:0], new_index[11:6],
                                                        // distance[36:12], zero[39:37]
   output logic                             rsp_tlast   // last
);
   import ped_pkg::*;

   // sequencer state
   ped_state_type     state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  n_ff, n_in;
   logic [IDX_W-1:0]  j_ff, j_in;
   ped_point_type     cur_ff, cur_in;

   // read stage: memory output register plus its tag
   logic              s0_vld_ff, s0_vld_in;
   ped_tag_type       s0_tag_ff, s0_tag_in;

   // result register
   logic              rsp_tvalid_ff;
   logic [DIST_W-1:0] rsp_dist_ff;
   ped_tag_type       rsp_tag_ff;

   logic              adv;
   logic              req_accept;
   logic [CNT_W-1:0]  base_count;
   logic              store;
   logic              scan_last;
   ped_point_type     req_pt;
   ped_point_type     mem_rd_pt;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;

   logic              sd_vld;
   logic [RAD_W-1:0]  sd_rad;
   ped_tag_type       sd_tag;
   logic              sq_vld;
   logic [ROOT_W-1:0] sq_root;
   ped_tag_type       sq_tag;

   // the whole pipeline moves together whenever the result register can take a word
   assign adv = !rsp_tvalid_ff || rsp_tready;

   // accept only when idle and the read stage will not be left holding
   // a word that still needs the current vertex
   assign req_tready = (state_ff == ST_IDLE) && !(s0_vld_ff && !adv);
   assign req_accept = req_tvalid && req_tready;

   assign req_pt.x = req_tdata[COORD_W-1:0];
   assign req_pt.y = req_tdata[2*COORD_W-1:COORD_W];

   // restart clears the count before the vertex is stored; a full store drops it
   assign base_count = req_tuser ? '0 : count_ff;
   assign store      = req_accept && (base_count != CNT_W'(MAX_VERTICES));
   assign scan_last  = (j_ff == n_ff - IDX_W'(1));

   assign wr_en   = store;
   assign wr_addr = base_count[IDX_W-1:0];

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      n_in      = n_ff;
      j_in      = j_ff;
      cur_in    = cur_ff;
      s0_vld_in = s0_vld_ff;
      s0_tag_in = s0_tag_ff;

      if (adv) begin
         s0_vld_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (store) begin
               count_in = base_count + CNT_W'(1);
               n_in     = base_count[IDX_W-1:0];
               j_in     = '0;
               cur_in   = req_pt;
               // the first vertex of an instance has nothing to pair with
               if (base_count != '0) begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            if (adv) begin
               s0_vld_in               = 1'b1;
               s0_tag_in.earlier_index = OUT_IDX_W'(j_ff);
               s0_tag_in.new_index     = OUT_IDX_W'(n_ff);
               s0_tag_in.last          = scan_last;
               j_in                    = j_ff + IDX_W'(1);
               if (scan_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         s0_vld_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         s0_vld_ff <= s0_vld_in;
         if (adv) begin
            rsp_tvalid_ff <= sq_vld;
         end
      end
      n_ff      <= n_in;
      j_ff      <= j_in;
      cur_ff    <= cur_in;
      s0_tag_ff <= s0_tag_in;
      if (adv) begin
         rsp_dist_ff <= DIST_W'(sq_root);
         rsp_tag_ff  <= sq_tag;
      end
   end

   // Writes happen only in idle and the reads whose data is used happen only while scanning
   // entries below the new index, so a used read never meets a write to the same entry.
   ped_ram #(
      .WIDTH ($bits(ped_point_type)),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_pt),
      .rd_en   (adv),
      .rd_addr (j_ff),
      .rd_data (mem_rd_pt)
   );

   ped_sqdist u_sqdist (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s0_vld_ff),
      .stored_pt (mem_rd_pt),
      .cur_pt    (cur_ff),
      .in_tag    (s0_tag_ff),
      .out_valid (sd_vld),
      .out_rad   (sd_rad),
      .out_tag   (sd_tag)
   );

   ped_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (sd_vld),
      .in_rad    (sd_rad),
      .in_tag    (sd_tag),
      .out_valid (sq_vld),
      .out_root  (sq_root),
      .out_tag   (sq_tag)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - DIST_W - 2*OUT_IDX_W){1'b0}}, rsp_dist_ff,
                        rsp_tag_ff.new_index, rsp_tag_ff.earlier_index};
   assign rsp_tlast  = rsp_tag_ff.last;

   // count never passes the store depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_VERTICES))
      else $error("vertex count beyond capacity");

   // the scan index stays below the new vertex index
   a_scan_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (j_ff < n_ff))
      else $error("scan index out of range");

   // issuing the final read ends the scan
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && adv && scan_last) |=> (state_ff == ST_IDLE))
      else $error("scan did not end after final read");

   // a stored vertex with earlier vertices starts a scan
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (store && base_count != '0) |=> (state_ff == ST_SCAN && count_ff != '0))
      else $error("stored vertex did not start a scan");

   // no vertex is taken while a scan is running
   a_no_accept_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !req_tready)
      else $error("input ready during scan");

endmodule

// File: src/ped_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module ped_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/ped_sqdist.sv
// Squared distance front end: absolute differences, squares, sum.
module ped_sqdist (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  ped_pkg::ped_point_type      stored_pt,
   input  ped_pkg::ped_point_type      cur_pt,
   input  ped_pkg::ped_tag_type        in_tag,
   output logic                        out_valid,
   output logic [ped_pkg::RAD_W-1:0]   out_rad,
   output ped_pkg::ped_tag_type        out_tag
);
   import ped_pkg::*;

   logic [COORD_W:0]   dx_s;
   logic [COORD_W:0]   dy_s;
   logic [DIFF_W-1:0]  dx_abs;
   logic [DIFF_W-1:0]  dy_abs;

   logic               v1_ff, v2_ff, v3_ff;
   ped_tag_type        t1_ff, t2_ff, t3_ff;
   logic [DIFF_W-1:0]  dx_ff, dy_ff;
   logic [SQ_W-1:0]    sqx_ff, sqy_ff;
   logic [RAD_W-1:0]   sum_ff;

   always_comb begin
      dx_s   = {stored_pt.x[COORD_W-1], stored_pt.x} - {cur_pt.x[COORD_W-1], cur_pt.x};
      dy_s   = {stored_pt.y[COORD_W-1], stored_pt.y} - {cur_pt.y[COORD_W-1], cur_pt.y};
      dx_abs = dx_s[COORD_W] ? DIFF_W'(-dx_s) : DIFF_W'(dx_s);
      dy_abs = dy_s[COORD_W] ? DIFF_W'(-dy_s) : DIFF_W'(dy_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      if (adv) begin
         dx_ff  <= dx_abs;
         dy_ff  <= dy_abs;
         t1_ff  <= in_tag;
         sqx_ff <= SQ_W'(dx_ff) * SQ_W'(dx_ff);
         sqy_ff <= SQ_W'(dy_ff) * SQ_W'(dy_ff);
         t2_ff  <= t1_ff;
         sum_ff <= RAD_W'(sqx_ff) + RAD_W'(sqy_ff);
         t3_ff  <= t2_ff;
      end
   end

   assign out_valid = v3_ff;
   assign out_rad   = sum_ff;
   assign out_tag   = t3_ff;

endmodule

// File: src/ped_isqrt.sv
// Pipelined floor square root, one result bit per stage.
module ped_isqrt (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        adv,
   input  logic                        in_valid,
   input  logic [ped_pkg::RAD_W-1:0]   in_rad,
   input  ped_pkg::ped_tag_type        in_tag,
   output logic                        out_valid,
   output logic [ped_pkg::ROOT_W-1:0]  out_root,
   output ped_pkg::ped_tag_type        out_tag
);
   import ped_pkg::*;

   logic                vld_w  [ROOT_W];
   logic [RAD_W-1:0]    rad_w  [ROOT_W];
   logic [REM_W-1:0]    rem_w  [ROOT_W];
   logic [ROOT_W-1:0]   root_w [ROOT_W];
   ped_tag_type         tag_w  [ROOT_W];

   logic                vld_ff  [ROOT_W];
   logic [RAD_W-1:0]    rad_ff  [ROOT_W];
   logic [REM_W-1:0]    rem_ff  [ROOT_W];
   logic [ROOT_W-1:0]   root_ff [ROOT_W];
   ped_tag_type         tag_ff  [ROOT_W];

   assign vld_w[0]  = in_valid;
   assign rad_w[0]  = in_rad;
   assign rem_w[0]  = '0;
   assign root_w[0] = '0;
   assign tag_w[0]  = in_tag;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
      logic [REM_W+1:0] trial;
      logic [REM_W+1:0] test;
      logic             ge;

      // bring down the next two radicand bits and try the next root bit
      assign trial = {rem_w[k], rad_w[k][RAD_W-1 -: 2]};
      assign test  = {1'b0, root_w[k], 2'b01};
      assign ge    = (trial >= test);

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_w[k];
         end
         if (adv) begin
            rad_ff[k]  <= rad_w[k] << 2;
            rem_ff[k]  <= ge ? REM_W'(trial - test) : REM_W'(trial);
            root_ff[k] <= {root_w[k][ROOT_W-2:0], ge};
            tag_ff[k]  <= tag_w[k];
         end
      end

      if (k < ROOT_W - 1) begin : g_link
         assign vld_w[k+1]  = vld_ff[k];
         assign rad_w[k+1]  = rad_ff[k];
         assign rem_w[k+1]  = rem_ff[k];
         assign root_w[k+1] = root_ff[k];
         assign tag_w[k+1]  = tag_ff[k];
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign out_root  = root_ff[ROOT_W-1];
   assign out_tag   = tag_ff[ROOT_W-1];

endmodule

// File: bench/pairwise_euclidean_distance_unit_tb.sv
// Self-checking bench for the pairwise Euclidean distance unit: directed, capacity and random tests.
module pairwise_euclidean_distance_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ped_pkg::*;

   localparam int CLK_HALF_NS   = 5;
   localparam int RESET_CYCLES  = 6;
   // Margin for the pipeline to settle after the drain, before the final check.
   localparam int SETTLE_CYCLES = 48;
   // Quiet cycles tolerated on both channels before the run is declared hung.
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int ITEMS_PER_PHASE = 100;

   localparam logic [COORD_W-1:0] COORD_MAX  = 24'h7F_FFFF;
   localparam logic [COORD_W-1:0] COORD_MIN  = 24'h80_0000;
   localparam logic [COORD_W-1:0] COORD_ZERO = 24'h00_0000;
   localparam logic [COORD_W-1:0] COORD_NEG1 = 24'hFF_FFFF;

   // One expected distance transaction.
   typedef struct {
      logic [OUT_IDX_W-1:0] earlier_index;
      logic [OUT_IDX_W-1:0] new_index;
      logic [DIST_W-1:0]    distance;
      logic                 last;
   } distance_entry_type;

   // Clock, reset and DUT ports; every input starts at a known value.
   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;   // coord_x[23:0], coord_y[47:24]
   logic                  req_tuser  = 1'b0; // restart
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;         // earlier_index[5:0], new_index[11:6],
                                             // distance[36:12], zero[39:37]
   logic                  rsp_tlast;         // last

   // Local copy of the vertex store, kept in step with accepted vertices.
   logic signed [COORD_W-1:0] vertex_x [MAX_VERTICES];
   logic signed [COORD_W-1:0] vertex_y [MAX_VERTICES];
   int unsigned               stored_vertices = 0;

   distance_entry_type pending_distances [$];

   // Idle settings for the current phase, in percent.
   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;

   int unsigned error_count     = 0;
   int unsigned vertices_sent   = 0;
   int unsigned vertices_stored = 0;
   int unsigned vertices_dropped = 0;
   int unsigned restarts_sent   = 0;
   int unsigned distances_seen  = 0;
   int unsigned quiet_cycles    = 0;

   pairwise_euclidean_distance_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always #(CLK_HALF_NS) clock = ~clock;

   // Floor square root by the digit-by-digit method; exact for 50-bit radicands.
   function automatic logic [DIST_W-1:0] floor_root(input longint unsigned radicand);
      longint unsigned rem;
      longint unsigned root;
      longint unsigned probe;
      rem   = radicand;
      root  = 0;
      probe = 64'd1 << 62;
      while (probe > rem) probe >>= 2;
      while (probe != 0) begin
         if (rem >= root + probe) begin
            rem  = rem - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe >>= 2;
      end
      return root[DIST_W-1:0];
   endfunction

   function automatic longint unsigned abs_delta(input logic signed [COORD_W-1:0] a,
                                                 input logic signed [COORD_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      return (d < 0) ? longint'(-d) : longint'(d);
   endfunction

   // Update the local store for one accepted vertex and queue the distances it causes.
   task automatic predict_distances(input logic signed [COORD_W-1:0] x,
                                    input logic signed [COORD_W-1:0] y,
                                    input logic restart);
      int unsigned        idx;
      longint unsigned    dx;
      longint unsigned    dy;
      distance_entry_type entry;
      if (restart) stored_vertices = 0;
      // Full store: drop the vertex, nothing changes.
      if (stored_vertices >= MAX_VERTICES) begin
         vertices_dropped++;
         return;
      end
      idx = stored_vertices;
      vertex_x[idx] = x;
      vertex_y[idx] = y;
      stored_vertices = idx + 1;
      vertices_stored++;
      for (int unsigned j = 0; j < idx; j++) begin
         dx = abs_delta(vertex_x[j], x);
         dy = abs_delta(vertex_y[j], y);
         entry.earlier_index = j[OUT_IDX_W-1:0];
         entry.new_index     = idx[OUT_IDX_W-1:0];
         entry.distance      = floor_root(dx * dx + dy * dy);
         entry.last          = (j + 1 == idx);
         pending_distances   = {pending_distances, entry};
      end
   endtask

   // Send one vertex: idle at random, then hold valid until the transaction is accepted.
   task automatic send_vertex(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
                              input logic restart);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      req_tuser  <= restart;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      vertices_sent++;
      if (restart) restarts_sent++;
      predict_distances(x, y, restart);
   endtask

   // Lower valid and hold off until every queued distance has arrived.
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_distances.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [COORD_W-1:0] pick_coord();
      logic [COORD_W-1:0] c;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0: c = COORD_MAX;
               1: c = COORD_MIN;
               2: c = COORD_ZERO;
               default: c = COORD_NEG1;
            endcase
         end
         // Small values around zero give short, exactly checkable distances.
         1, 2: c = COORD_W'($urandom_range(0, 511)) - COORD_W'(256);
         default: c = COORD_W'($urandom);
      endcase
      return c;
   endfunction

   // Extremes of both coordinates, coincident points and restart handling.
   task automatic test_directed();
      send_vertex(COORD_ZERO, COORD_ZERO, 1'b0);   // first vertex after reset
      send_vertex(COORD_MAX,  COORD_MAX,  1'b0);
      send_vertex(COORD_MIN,  COORD_MIN,  1'b0);   // largest possible distance
      send_vertex(COORD_MIN,  COORD_MAX,  1'b0);
      send_vertex(COORD_MAX,  COORD_MIN,  1'b0);
      send_vertex(COORD_ZERO, COORD_NEG1, 1'b0);
      send_vertex(24'h00_0001, COORD_ZERO, 1'b0);
      send_vertex(24'hAA_AAAA, 24'h55_5555, 1'b0);
      send_vertex(24'h55_5555, 24'hAA_AAAA, 1'b0);
      send_vertex(24'h00_0100, 24'h00_0100, 1'b1); // restart mid-instance
      send_vertex(24'h00_0100, 24'h00_0100, 1'b0); // coincident point, zero distance
      send_vertex(24'h00_0300, 24'h00_0400, 1'b0); // 2:3 offset from the previous vertex
      send_vertex(COORD_ZERO, COORD_ZERO, 1'b1);   // back-to-back restarts
      send_vertex(COORD_ZERO, COORD_ZERO, 1'b1);
      send_vertex(COORD_MIN,  COORD_ZERO, 1'b0);
      send_vertex(COORD_MAX,  COORD_ZERO, 1'b0);
      wait_for_drain();
   endtask

   // Fill the store, offer extra vertices that must be dropped, then restart from full.
   task automatic test_capacity();
      send_vertex(pick_coord(), pick_coord(), 1'b1);
      for (int i = 1; i < MAX_VERTICES; i++) send_vertex(pick_coord(), pick_coord(), 1'b0);
      for (int i = 0; i < 3; i++) send_vertex(pick_coord(), pick_coord(), 1'b0);
      send_vertex(pick_coord(), pick_coord(), 1'b1);
      send_vertex(pick_coord(), pick_coord(), 1'b0);
   endtask

   // Random instances: mostly short runs opened by a restart, now and then a long one
   // that can fill or overflow the store, with a few stray restarts to break runs apart.
   task automatic test_random_instances(input int unsigned target);
      int unsigned start_stored;
      int unsigned run_len;
      logic        rs;
      start_stored = vertices_stored;
      while (vertices_stored - start_stored < target) begin
         run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 70)
                                               : $urandom_range(1, 16);
         for (int unsigned k = 0; k < run_len; k++) begin
            rs = (k == 0) ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 49) == 0);
            send_vertex(pick_coord(), pick_coord(), rs);
         end
      end
   endtask

   // Run the random test under one idle setting, then drain before the next.
   task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
      send_idle_pct  = idle_pct;
      recv_stall_pct = stall_pct;
      test_random_instances(ITEMS_PER_PHASE);
      wait_for_drain();
   endtask

   // Compare one accepted distance transaction against the oldest expectation.
   task automatic check_distance();
      distance_entry_type want;
      distances_seen++;
      if (pending_distances.size() == 0) begin
         $error("unexpected distance transaction: tdata=%h tlast=%b", rsp_tdata, rsp_tlast);
         error_count++;
         return;
      end
      want = pending_distances.pop_front();
      if (rsp_tdata[5:0] !== want.earlier_index) begin
         $error("earlier_index: expected %0d, got %0d", want.earlier_index, rsp_tdata[5:0]);
         error_count++;
      end
      if (rsp_tdata[11:6] !== want.new_index) begin
         $error("new_index: expected %0d, got %0d", want.new_index, rsp_tdata[11:6]);
         error_count++;
      end
      if (rsp_tdata[36:12] !== want.distance) begin
         $error("distance: expected %0d, got %0d", want.distance, rsp_tdata[36:12]);
         error_count++;
      end
      if (rsp_tdata[39:37] !== 3'b000) begin
         $error("padding: expected 0, got %0d", rsp_tdata[39:37]);
         error_count++;
      end
      if (rsp_tlast !== want.last) begin
         $error("last: expected %0b, got %0b", want.last, rsp_tlast);
         error_count++;
      end
   endtask

   // Sample results on the edge, then pick the next ready value for this phase.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) check_distance();
      rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   // Count cycles with no transaction on either channel; end the run if it hangs.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction in %0d cycles, %0d distances outstanding",
                     WATCHDOG_LIMIT, pending_distances.size());
            $display("Mismatches found");
            $finish;
         end
      end
   end

   initial begin
      // Hold reset, then release it on a rising edge.
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_capacity();
      wait_for_drain();

      // Idle phases: none, slow sender, slow receiver, both a little.
      run_phase(0, 0);
      run_phase(78, 0);
      run_phase(0, 78);
      run_phase(24, 24);

      // Drain, then let the pipeline settle so stray transactions show up.
      wait_for_drain();

      $display("Sent %0d vertices (%0d restarts, %0d dropped at capacity), checked %0d distances",
               vertices_sent, restarts_sent, vertices_dropped, distances_seen);
      $display("Covered coordinate extremes, coincident points, full store and four idle mixes");
      if (error_count == 0 && pending_distances.size() == 0) begin
         $display("No mismatches found");
      end else begin
         if (pending_distances.size() != 0)
            $error("%0d expected distances never arrived", pending_distances.size());
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
